FILE: hw/rtl/gbpe_pkg.sv
// Shared types, constants and helper functions for the glyph bitmap pixel expander.
// Used by the channel interfaces and every RTL module of the block.
`timescale 1ns / 1ps
package gbpe_pkg;

    localparam int BITS_PER_BYTE   = 8;
    localparam int MAX_GLYPH_WIDTH = 64;
    localparam int BIT_IDX_W       = $clog2(BITS_PER_BYTE);
    localparam int BIT_CNT_W       = $clog2(BITS_PER_BYTE + 1);
    localparam int COL_W           = $clog2(MAX_GLYPH_WIDTH);
    localparam int GW_W            = 7;
    localparam int ORIGIN_W        = 10;
    localparam int COORD_W         = 11;
    localparam int COLOR_W         = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FG_COLOR    = 2'd0,
        CFG_BG_COLOR    = 2'd1,
        CFG_GLYPH_WIDTH = 2'd2,
        CFG_TRANSPARENT = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
        logic [GW_W-1:0]    glyph_width;
        logic               transparent;
    } t_cfg;

    typedef struct packed {
        logic [BITS_PER_BYTE-1:0] mask;
        logic [BITS_PER_BYTE-1:0] bits;
        logic [COORD_W-1:0]       base_x;
        logic [COORD_W-1:0]       row;
    } t_job;

    function automatic logic [BITS_PER_BYTE-1:0] prefix_mask(input logic [BIT_CNT_W-1:0] n);
        logic [BITS_PER_BYTE-1:0] m;
        m = '0;
        for (int k = 0; k < BITS_PER_BYTE; k++) begin
            m[k] = (BIT_CNT_W'(k) < n);
        end
        return m;
    endfunction

    function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [BITS_PER_BYTE-1:0] v);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int k = BITS_PER_BYTE - 1; k >= 0; k--) begin
            if (v[k]) begin
                idx = BIT_IDX_W'(k);
            end
        end
        return idx;
    endfunction

endpackage

FILE: hw/rtl/gbpe_if.sv
// Valid/ready channel interfaces: bitmap byte input, pixel output, register writes.
// Depends on gbpe_pkg for field widths.
`timescale 1ns / 1ps
interface gbpe_in_if import gbpe_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [BITS_PER_BYTE-1:0] bits;
    logic                     start_req;
    logic [ORIGIN_W-1:0]      origin_x;
    logic [ORIGIN_W-1:0]      origin_y;

    modport source (output valid, bits, start_req, origin_x, origin_y, input ready);
    modport sink   (input valid, bits, start_req, origin_x, origin_y, output ready);
endinterface

interface gbpe_out_if import gbpe_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

interface gbpe_cfg_if import gbpe_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/gbpe_front.sv
// Front end: accepts bitmap bytes, tracks column, left edge and row, builds pixel jobs.
// Depends on gbpe_pkg.
`timescale 1ns / 1ps
module gbpe_front import gbpe_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [BITS_PER_BYTE-1:0] i_bits,
    input  logic                i_start_req,
    input  logic [ORIGIN_W-1:0] i_origin_x,
    input  logic [ORIGIN_W-1:0] i_origin_y,
    input  logic                i_queue_full,
    output logic                o_push,
    output t_job                o_job
);

    logic [COL_W-1:0]    r_column,    n_column;
    logic [ORIGIN_W-1:0] r_left_edge, n_left_edge;
    logic [COORD_W-1:0]  r_row,       n_row;

    logic [GW_W-1:0]          width;
    logic [COL_W-1:0]         col;
    logic [ORIGIN_W-1:0]      left;
    logic [COORD_W-1:0]       row;
    logic [GW_W-1:0]          rem;
    logic [BIT_CNT_W-1:0]     n_bits;
    logic                     wraps;
    logic [BITS_PER_BYTE-1:0] span;
    logic                     accept;

    always_comb begin
        if (i_cfg.glyph_width == '0) begin
            width = GW_W'(1);
        end else if (i_cfg.glyph_width > GW_W'(MAX_GLYPH_WIDTH)) begin
            width = GW_W'(MAX_GLYPH_WIDTH);
        end else begin
            width = i_cfg.glyph_width;
        end

        col  = i_start_req ? '0 : r_column;
        left = i_start_req ? i_origin_x : r_left_edge;
        row  = i_start_req ? COORD_W'(i_origin_y) : r_row;

        if (width > GW_W'(col)) begin
            rem = width - GW_W'(col);
        end else begin
            rem = GW_W'(1);
        end
        wraps  = (rem <= GW_W'(BITS_PER_BYTE));
        n_bits = wraps ? BIT_CNT_W'(rem) : BIT_CNT_W'(BITS_PER_BYTE);
        span   = prefix_mask(n_bits);

        o_job.mask   = i_cfg.transparent ? (span & i_bits) : span;
        o_job.bits   = i_bits;
        o_job.base_x = COORD_W'(left) + COORD_W'(col);
        o_job.row    = row;

        o_ready = !i_queue_full;
        accept  = i_valid && o_ready;
        o_push  = accept && (o_job.mask != '0);

        n_left_edge = left;
        if (wraps) begin
            n_column = '0;
            n_row    = row + COORD_W'(1);
        end else begin
            n_column = col + COL_W'(n_bits);
            n_row    = row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_left_edge <= '0;
            r_row       <= '0;
        end else if (accept) begin
            r_column    <= n_column;
            r_left_edge <= n_left_edge;
            r_row       <= n_row;
        end
    end

endmodule

FILE: hw/rtl/gbpe_queue.sv
// Two-entry job queue between front and back end.
// Depends on gbpe_pkg for the job type and depth.
`timescale 1ns / 1ps
module gbpe_queue import gbpe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_head
);

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wp;
    logic [QUEUE_PTR_W-1:0] r_rp;
    logic [QUEUE_CNT_W-1:0] r_count;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QUEUE_PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QUEUE_PTR_W'(1);
            end
            r_count <= r_count + QUEUE_CNT_W'(i_push) - QUEUE_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

FILE: hw/rtl/gbpe_back.sv
// Back end: walks job masks into the output register, one pixel per cycle unless stalled.
// Depends on gbpe_pkg.
`timescale 1ns / 1ps
module gbpe_back import gbpe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_valid,
    input  t_job               i_q_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COORD_W-1:0] o_pixel_x,
    output logic [COORD_W-1:0] o_pixel_y,
    output logic [COLOR_W-1:0] o_pixel_color,
    output logic               o_last
);

    logic                     r_busy;
    logic [BITS_PER_BYTE-1:0] r_rem;
    logic [BITS_PER_BYTE-1:0] r_bits;
    logic [COORD_W-1:0]       r_x;
    logic [COORD_W-1:0]       r_y;
    logic                     r_ov;
    logic [COORD_W-1:0]       r_px;
    logic [COORD_W-1:0]       r_py;
    logic [COLOR_W-1:0]       r_pc;
    logic                     r_pl;

    logic [BIT_IDX_W-1:0]     idx;
    logic [BITS_PER_BYTE-1:0] n_rem;
    logic                     is_last;
    logic                     adv;

    always_comb begin
        idx     = lowest_set(r_rem);
        n_rem   = r_rem & ~(BITS_PER_BYTE'(1) << idx);
        is_last = (n_rem == '0);
        adv     = r_busy && (!r_ov || i_ready);
        o_pop   = i_q_valid && (!r_busy || (adv && is_last));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (adv && is_last) begin
                r_busy <= 1'b0;
            end
            if (adv) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem  <= i_q_head.mask;
            r_bits <= i_q_head.bits;
            r_x    <= i_q_head.base_x;
            r_y    <= i_q_head.row;
        end else if (adv) begin
            r_rem <= n_rem;
        end
        if (adv) begin
            r_px <= r_x + COORD_W'(idx);
            r_py <= r_y;
            r_pc <= r_bits[idx] ? i_cfg.fg_color : i_cfg.bg_color;
            r_pl <= is_last;
        end
    end

    assign o_valid       = r_ov;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pc;
    assign o_last        = r_pl;

endmodule

FILE: hw/rtl/glyph_bitmap_pixel_expander.sv
// Glyph bitmap pixel expander top level: register file, front end, job queue, back end.
// Depends on gbpe_pkg, gbpe_if, gbpe_front, gbpe_queue and gbpe_back.
//
// Usage:
//   i_in takes one bitmap byte per item, bit 0 leftmost; start_req places a new
//   glyph at origin_x/origin_y before the byte is expanded.
//   o_pix gives one pixel per item (x, y, RGB565 colour); last marks the final
//   pixel of each byte. A byte that draws nothing gives no item.
//   i_cfg writes fg_color, bg_color, glyph_width and transparent by index; it is
//   always ready; write it only while the block is idle (the block does not enforce
//   this). The back end walks the byte mask, one pixel per cycle while the receiver
//   is ready: up to 8 pixels per byte (fewer at a row end or in transparent mode).
//   The front end takes a byte per cycle while the two-entry queue has room.
//   Reset clears coordinates and loads the register reset values; outputs go idle.
//   A receiver stall holds the output pixel; the queue then fills and i_in.ready
//   drops until pixels drain.
`timescale 1ns / 1ps
module glyph_bitmap_pixel_expander import gbpe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gbpe_in_if.sink    i_in,
    gbpe_out_if.source o_pix,
    gbpe_cfg_if.sink   i_cfg
);

    t_cfg r_cfg;
    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_job job;
    t_job head;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fg_color    <= '1;
            r_cfg.bg_color    <= '0;
            r_cfg.glyph_width <= GW_W'(8);
            r_cfg.transparent <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_FG_COLOR:    r_cfg.fg_color    <= i_cfg.data[COLOR_W-1:0];
                CFG_BG_COLOR:    r_cfg.bg_color    <= i_cfg.data[COLOR_W-1:0];
                CFG_GLYPH_WIDTH: r_cfg.glyph_width <= i_cfg.data[GW_W-1:0];
                CFG_TRANSPARENT: r_cfg.transparent <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    gbpe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_bits       (i_in.bits),
        .i_start_req  (i_in.start_req),
        .i_origin_x   (i_in.origin_x),
        .i_origin_y   (i_in.origin_y),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_job        (job)
    );

    gbpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    gbpe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (q_valid),
        .i_q_head      (head),
        .o_pop         (pop),
        .o_valid       (o_pix.valid),
        .i_ready       (o_pix.ready),
        .o_pixel_x     (o_pix.pixel_x),
        .o_pixel_y     (o_pix.pixel_y),
        .o_pixel_color (o_pix.pixel_color),
        .o_last        (o_pix.last)
    );

endmodule

FILE: hw/rtl/gbpe_checker.sv
// Port-level checks for the glyph bitmap pixel expander, bound to the top level.
// Depends on gbpe_pkg and glyph_bitmap_pixel_expander.
`timescale 1ns / 1ps
module gbpe_checker import gbpe_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [COORD_W-1:0] i_pixel_x,
    input logic [COORD_W-1:0] i_pixel_y,
    input logic [COLOR_W-1:0] i_pixel_color,
    input logic               i_last
);

    a_reset_idle: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (!i_out_valid && i_in_ready))
        else $error("outputs not idle after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_pixel_x) && $stable(i_pixel_y)
             && $stable(i_pixel_color) && $stable(i_last)))
        else $error("stalled pixel changed");

    a_byte_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_last) |=> i_out_valid)
        else $error("gap inside a byte's pixels");

    a_byte_same_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_last) |=>
            ($stable(i_pixel_y) && (i_pixel_x != $past(i_pixel_x))))
        else $error("pixels of one byte left the row or repeated a column");

endmodule

bind glyph_bitmap_pixel_expander gbpe_checker u_gbpe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_pix.valid),
    .i_out_ready   (o_pix.ready),
    .i_pixel_x     (o_pix.pixel_x),
    .i_pixel_y     (o_pix.pixel_y),
    .i_pixel_color (o_pix.pixel_color),
    .i_last        (o_pix.last)
);
